// ===== rtl/core/segmented_big_endian_memory_access_unit_assert.svh =====
// Assertion macros shared by the load/store unit modules.
`ifndef SEGMENTED_BIG_ENDIAN_MEMORY_ACCESS_UNIT_ASSERT_SVH
`define SEGMENTED_BIG_ENDIAN_MEMORY_ACCESS_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define SBE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("sbe assertion failed");

// Check that a condition never holds outside reset.
`define SBE_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("sbe forbidden condition seen");

`endif

// ===== rtl/core/sbe_pkg.sv =====
// Types and constants of the segmented big-endian load/store unit.
package sbe_pkg;

  // Access status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NO_REGION  = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_BAD_SIZE   = 3'd3,
    ST_RANGE      = 3'd4
  } status_e;

  // Access size codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Access kind codes
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Region selectors found in address bits 31:20
  localparam logic [11:0] SEL_PROGRAM = 12'h004;
  localparam logic [11:0] SEL_DATA    = 12'h100;
  localparam logic [11:0] SEL_STACK   = 12'h7FF;

  // Region codes used as the top bits of a lane RAM address
  localparam logic [1:0] REG_PROGRAM = 2'd0;
  localparam logic [1:0] REG_DATA    = 2'd1;
  localparam logic [1:0] REG_STACK   = 2'd2;

  localparam int unsigned OFFSET_BITS = 20;
  localparam int unsigned NUM_LANES   = 4;
  localparam int unsigned REQ_DEPTH   = 2;
  localparam int unsigned RES_DEPTH   = 4;

  // Classified access, handed from the front to the back
  typedef struct packed {
    status_e                  status;
    logic                     is_write;
    logic [1:0]               size;
    logic [1:0]               region;
    logic [OFFSET_BITS-1:0]   offset;
    logic [NUM_LANES-1:0]     lane_en;
    logic [NUM_LANES-1:0][7:0] lane_wdata;
  } req_t;

  // Finished result transaction
  typedef struct packed {
    logic [31:0] read_data;
    status_e     status;
  } result_t;

endpackage

// ===== rtl/core/sbe_ram.sv =====
// Generic single-port RAM with registered read data.
module sbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write or read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sbe_fifo.sv =====
// Small register FIFO used for the request and result queues.
`include "segmented_big_endian_memory_access_unit_assert.svh"

module sbe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic [CW-1:0]    count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    count_d = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `SBE_ASSERT_NEVER(a_no_push_when_full, clk_i, rst_ni, push_i && full_o)

endmodule

// ===== rtl/core/sbe_front.sv =====
// Front end: accept accesses, classify them and queue them for the back end.
module sbe_front #(
  parameter int unsigned REGION_ADDR_BITS = 20
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [31:0]   address_i,
  input  logic [31:0]   write_data_i,
  input  logic          func_i,
  input  logic [1:0]    size_i,
  output logic          req_valid_o,
  output sbe_pkg::req_t req_o,
  input  logic          req_pop_i
);

  import sbe_pkg::*;

  logic [11:0]            sel;
  logic [OFFSET_BITS-1:0] offset;
  logic                   region_ok;
  logic [1:0]             region;
  logic                   misaligned;
  logic                   out_of_range;
  req_t                   req;
  logic                   req_empty;

  assign sel    = address_i[31:20];
  assign offset = address_i[OFFSET_BITS-1:0];

  // Decode the region selector
  always_comb begin
    region_ok = 1'b1;
    case (sel)
      SEL_PROGRAM: region = REG_PROGRAM;
      SEL_DATA:    region = REG_DATA;
      SEL_STACK:   region = REG_STACK;
      default: begin
        region    = REG_PROGRAM;
        region_ok = 1'b0;
      end
    endcase
  end

  assign misaligned = ((size_i == SIZE_HALF) && offset[0]) ||
                      ((size_i == SIZE_WORD) && (offset[1:0] != 2'b00));
  assign out_of_range = ((32'(offset) >> REGION_ADDR_BITS) != 32'd0);

  // Classify the access and spread write bytes over lanes, big-endian
  always_comb begin
    req          = '0;
    req.is_write = (func_i == FUNC_WRITE);
    req.size     = size_i;
    req.region   = region;
    req.offset   = offset;
    if (!region_ok) begin
      req.status = ST_NO_REGION;
    end else if (!(size_i inside {SIZE_BYTE, SIZE_HALF, SIZE_WORD})) begin
      req.status = ST_BAD_SIZE;
    end else if (misaligned) begin
      req.status = ST_MISALIGNED;
    end else if (out_of_range) begin
      req.status = ST_RANGE;
    end else begin
      req.status = ST_OK;
    end
    case (size_i)
      SIZE_BYTE: begin
        req.lane_en[offset[1:0]] = 1'b1;
        for (int k = 0; k < NUM_LANES; k++) begin
          req.lane_wdata[k] = write_data_i[7:0];
        end
      end
      SIZE_HALF: begin
        req.lane_en       = offset[1] ? 4'b1100 : 4'b0011;
        req.lane_wdata[0] = write_data_i[15:8];
        req.lane_wdata[1] = write_data_i[7:0];
        req.lane_wdata[2] = write_data_i[15:8];
        req.lane_wdata[3] = write_data_i[7:0];
      end
      SIZE_WORD: begin
        req.lane_en       = 4'b1111;
        req.lane_wdata[0] = write_data_i[31:24];
        req.lane_wdata[1] = write_data_i[23:16];
        req.lane_wdata[2] = write_data_i[15:8];
        req.lane_wdata[3] = write_data_i[7:0];
      end
      default: begin
        req.lane_en = '0;
      end
    endcase
  end

  // Hold classified transactions until the back end takes them
  sbe_fifo #(
    .WIDTH($bits(req_t)),
    .DEPTH(REQ_DEPTH)
  ) u_req_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && !full_o),
    .wdata_i (req),
    .full_o  (full_o),
    .pop_i   (req_pop_i),
    .rdata_o (req_o),
    .empty_o (req_empty),
    .count_o ()
  );

  assign req_valid_o = !req_empty;

endmodule

// ===== rtl/core/sbe_back.sv =====
// Back end: run accesses against the byte-lane RAMs and queue the results.
`include "segmented_big_endian_memory_access_unit_assert.svh"

module sbe_back #(
  parameter int unsigned REGION_ADDR_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  sbe_pkg::req_t        req_i,
  output logic                 req_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic signed [31:0]   read_data_o,
  output sbe_pkg::status_e     status_o
);

  import sbe_pkg::*;

  localparam int unsigned RAM_DEPTH = 2 ** REGION_ADDR_BITS;
  localparam int unsigned RCW       = $clog2(RES_DEPTH + 1);

  logic                          issue;
  logic                          req_ok;
  logic [REGION_ADDR_BITS-1:0]   lane_addr;
  logic [NUM_LANES-1:0][7:0]     lane_rdata;
  logic                          s1_valid_q;
  status_e                       s1_status_q;
  logic                          s1_write_q;
  logic [1:0]                    s1_size_q;
  logic [1:0]                    s1_off_q;
  logic [RCW-1:0]                res_count;
  logic                          res_full;
  result_t                       res_d;
  result_t                       res_q;
  logic [7:0]                    rd_byte;
  logic [15:0]                   rd_half;
  logic                          res_zero;

  // Issue only when the result queue has room for everything in flight
  assign issue = req_valid_i &&
                 ((res_count + RCW'(s1_valid_q)) < RCW'(RES_DEPTH));
  assign req_pop_o = issue;
  assign req_ok    = (req_i.status == ST_OK);
  assign lane_addr = {req_i.region, req_i.offset[REGION_ADDR_BITS-1:2]};

  // One RAM per byte lane, regions stacked in the upper address bits
  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    sbe_ram #(
      .WIDTH(8),
      .DEPTH(RAM_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .en_i    (issue && req_ok && req_i.lane_en[k]),
      .we_i    (req_i.is_write),
      .addr_i  (lane_addr),
      .wdata_i (req_i.lane_wdata[k]),
      .rdata_o (lane_rdata[k])
    );
  end

  // Track the transaction waiting for RAM read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_status_q <= req_i.status;
      s1_write_q  <= req_i.is_write;
      s1_size_q   <= req_i.size;
      s1_off_q    <= req_i.offset[1:0];
    end
  end

  // Assemble the big-endian value and sign-extend it
  assign rd_byte = lane_rdata[s1_off_q];
  assign rd_half = s1_off_q[1] ? {lane_rdata[2], lane_rdata[3]}
                               : {lane_rdata[0], lane_rdata[1]};

  always_comb begin
    res_d.status    = s1_status_q;
    res_d.read_data = '0;
    if ((s1_status_q == ST_OK) && !s1_write_q) begin
      case (s1_size_q)
        SIZE_BYTE: res_d.read_data = {{24{rd_byte[7]}}, rd_byte};
        SIZE_HALF: res_d.read_data = {{16{rd_half[15]}}, rd_half};
        SIZE_WORD: res_d.read_data = {lane_rdata[0], lane_rdata[1],
                                      lane_rdata[2], lane_rdata[3]};
        default:   res_d.read_data = '0;
      endcase
    end
  end

  // Hold finished results until the consumer pops them
  sbe_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s1_valid_q),
    .wdata_i (res_d),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (res_q),
    .empty_o (empty_o),
    .count_o (res_count)
  );

  assign read_data_o = signed'(res_q.read_data);
  assign status_o    = res_q.status;

  assign res_zero = (res_d.read_data == 32'd0);

  `SBE_ASSERT_NEVER(a_result_room, clk_i, rst_ni, s1_valid_q && res_full)
  `SBE_ASSERT(a_issue_lands, clk_i, rst_ni, issue |=> s1_valid_q)
  `SBE_ASSERT(a_error_zero, clk_i, rst_ni, (s1_valid_q && (s1_status_q != ST_OK)) |-> res_zero)
  `SBE_ASSERT(a_write_zero, clk_i, rst_ni, (s1_valid_q && s1_write_q) |-> res_zero)

endmodule

// ===== rtl/core/segmented_big_endian_memory_access_unit.sv =====
// Segmented big-endian load/store unit: takes one access per transaction and
// returns its read data and status. Address bits 31:20 choose the program
// (0x004), data (0x100) or stack (0x7FF) region; any other value reports "no
// region". Halfwords and words are big-endian, must be aligned, and read back
// sign-extended; writes and errors return zero read data. Offsets at or beyond
// 2**REGION_ADDR_BITS report "out of range". Each region is held in four
// byte-lane single-port RAMs, so one access is carried out per clock cycle
// while the result queue has room: sustained rate is one transaction per
// cycle while results are popped, set by the single port of each lane RAM. A
// result passes from the request queue through the RAM read into the result
// queue before it can be popped. Memory is not cleared at reset; reading a
// byte never written gives an unspecified value.
module segmented_big_endian_memory_access_unit #(
  parameter int unsigned REGION_ADDR_BITS = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [31:0]             address_i,
  input  logic [31:0]             write_data_i,
  input  logic                    func_i,
  input  logic [1:0]              size_i,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [31:0]      read_data_o,
  output logic [2:0]              status_o
);

  import sbe_pkg::*;

  logic    req_valid;
  req_t    req;
  logic    req_pop;
  status_e status;

  // Accept and classify transactions
  sbe_front #(
    .REGION_ADDR_BITS(REGION_ADDR_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .func_i       (func_i),
    .size_i       (size_i),
    .req_valid_o  (req_valid),
    .req_o        (req),
    .req_pop_i    (req_pop)
  );

  // Carry out transactions and queue results
  sbe_back #(
    .REGION_ADDR_BITS(REGION_ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .read_data_o (read_data_o),
    .status_o    (status)
  );

  assign status_o = status;

endmodule

// ===== tb/segmented_big_endian_memory_access_unit_test.sv =====
// Self-checking testbench for the segmented big-endian load/store unit.
module segmented_big_endian_memory_access_unit_test;
  import sbe_pkg::*;

  localparam int unsigned REGION_ADDR_BITS = 20;
  localparam int unsigned REGION_BYTES = 32'd1 << REGION_ADDR_BITS;
  localparam logic [19:0] REGION_MASK = 20'(REGION_BYTES - 1);
  localparam logic [1:0] SIZE_BAD = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned RANDOM_PER_PROFILE = 540;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [31:0] address_i = '0;
  logic [31:0] write_data_i = '0;
  logic func_i = FUNC_READ;
  logic [1:0] size_i = SIZE_BYTE;
  logic empty;
  logic pop = 1'b0;
  logic signed [31:0] read_data_o;
  logic [2:0] status_o;

  // Shadow memory: key is {region code, offset}
  logic [7:0] mem_bytes [int];
  int written_keys [$];
  result_t expected_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int accesses_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int status_count [5] = '{default: 0};

  segmented_big_endian_memory_access_unit #(
    .REGION_ADDR_BITS(REGION_ADDR_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .address_i   (address_i),
    .write_data_i(write_data_i),
    .func_i      (func_i),
    .size_i      (size_i),
    .empty       (empty),
    .pop         (pop),
    .read_data_o (read_data_o),
    .status_o    (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case the unit hangs
  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [11:0] sel_of(input logic [1:0] ridx);
    case (ridx)
      REG_PROGRAM: return SEL_PROGRAM;
      REG_DATA: return SEL_DATA;
      default: return SEL_STACK;
    endcase
  endfunction

  function automatic int byte_key(input logic [1:0] ridx, input logic [19:0] off);
    return int'({ridx, off & REGION_MASK});
  endfunction

  // Decode region, then size, alignment and range, in that order of priority
  function automatic status_e classify_access(input logic [31:0] addr, input logic [1:0] sz,
                                              output logic [1:0] ridx);
    logic [19:0] off;
    off = addr[19:0];
    ridx = REG_PROGRAM;
    case (addr[31:20])
      SEL_PROGRAM: ridx = REG_PROGRAM;
      SEL_DATA: ridx = REG_DATA;
      SEL_STACK: ridx = REG_STACK;
      default: return ST_NO_REGION;
    endcase
    if (sz == SIZE_BAD) return ST_BAD_SIZE;
    if ((off & ((20'd1 << sz) - 20'd1)) != 20'd0) return ST_MISALIGNED;
    if ({12'd0, off} >= REGION_BYTES) return ST_RANGE;
    return ST_OK;
  endfunction

  // Apply one access to the shadow memory and form its result
  task automatic predict_access(input logic [31:0] addr, input logic [31:0] wdata,
                                input logic fn, input logic [1:0] sz, output result_t res);
    logic [1:0] ridx;
    logic [31:0] value;
    int nbytes;
    int key;
    res.status = classify_access(addr, sz, ridx);
    res.read_data = '0;
    if (res.status == ST_OK) begin
      nbytes = 1 << sz;
      value = '0;
      for (int i = 0; i < nbytes; i++) begin
        key = byte_key(ridx, addr[19:0] + 20'(i));
        if (fn == FUNC_WRITE) begin
          if (!mem_bytes.exists(key)) written_keys.push_back(key);
          mem_bytes[key] = wdata[8*(nbytes-1-i) +: 8];
        end else begin
          value = {value[23:0], mem_bytes.exists(key) ? mem_bytes[key] : 8'h00};
        end
      end
      if (fn == FUNC_READ) begin
        case (sz)
          SIZE_BYTE: value = {{24{value[7]}}, value[7:0]};
          SIZE_HALF: value = {{16{value[15]}}, value[15:0]};
          default: ;
        endcase
        res.read_data = value;
      end
    end
    status_count[int'(res.status)]++;
  endtask

  // Offer one transaction, hold it until accepted, then record its result
  task automatic send_access(input logic [31:0] addr, input logic [31:0] wdata,
                             input logic fn, input logic [1:0] sz);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    address_i <= addr;
    write_data_i <= wdata;
    func_i <= fn;
    size_i <= sz;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_access(addr, wdata, fn, sz, res);
    expected_results.push_back(res);
    accesses_sent++;
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_results_drained();
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: stall pop at the current rate
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every popped transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t exp_res;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: read_data %h status %0d", read_data_o, status_o);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        results_checked++;
        if (read_data_o !== exp_res.read_data) begin
          $error("read_data expected %h actual %h", exp_res.read_data, read_data_o);
          mismatch_count++;
        end
        if (status_o !== exp_res.status) begin
          $error("status expected %0d actual %0d", exp_res.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  // Byte lanes, big-endian order and sign extension in every region
  task automatic test_big_endian_lanes();
    send_access({SEL_DATA, 20'h00000}, 32'h8123_4567, FUNC_WRITE, SIZE_WORD);
    send_access({SEL_DATA, 20'h00000}, 32'h0, FUNC_READ, SIZE_WORD);
    send_access({SEL_DATA, 20'h00000}, 32'h0, FUNC_READ, SIZE_HALF);
    send_access({SEL_DATA, 20'h00002}, 32'h0, FUNC_READ, SIZE_HALF);
    send_access({SEL_DATA, 20'h00000}, 32'h0, FUNC_READ, SIZE_BYTE);
    send_access({SEL_DATA, 20'h00003}, 32'h0, FUNC_READ, SIZE_BYTE);
    send_access({SEL_STACK, 20'hFFFFC}, 32'hFFFF_FFFF, FUNC_WRITE, SIZE_WORD);
    send_access({SEL_STACK, 20'hFFFFF}, 32'hFFFF_FF00, FUNC_WRITE, SIZE_BYTE);
    send_access({SEL_STACK, 20'hFFFFC}, 32'h0, FUNC_READ, SIZE_WORD);
    send_access({SEL_STACK, 20'hFFFFE}, 32'h0, FUNC_READ, SIZE_HALF);
    send_access({SEL_STACK, 20'hFFFFF}, 32'h0, FUNC_READ, SIZE_BYTE);
    send_access({SEL_PROGRAM, 20'h00000}, 32'h1234_7FFF, FUNC_WRITE, SIZE_HALF);
    send_access({SEL_PROGRAM, 20'h00000}, 32'h0, FUNC_READ, SIZE_HALF);
    send_access({SEL_PROGRAM, 20'h00005}, 32'h0000_0080, FUNC_WRITE, SIZE_BYTE);
    send_access({SEL_PROGRAM, 20'h00005}, 32'h0, FUNC_READ, SIZE_BYTE);
  endtask

  // Error decode priority; a rejected write must leave memory unchanged
  task automatic test_error_priority();
    send_access(32'h0000_0000, 32'h0, FUNC_READ, SIZE_BYTE);
    send_access(32'hFFFF_FFFF, 32'hFFFF_FFFF, FUNC_WRITE, SIZE_BAD);
    send_access({12'h005, 20'h00000}, 32'h0, FUNC_READ, SIZE_WORD);
    send_access({12'h0FF, 20'hFFFFF}, 32'h0, FUNC_WRITE, SIZE_HALF);
    send_access({SEL_DATA, 20'h00001}, 32'h0, FUNC_READ, SIZE_BAD);
    send_access({SEL_STACK, 20'h00000}, 32'h5A5A_5A5A, FUNC_WRITE, SIZE_BAD);
    send_access({SEL_DATA, 20'h00001}, 32'h0, FUNC_READ, SIZE_HALF);
    send_access({SEL_DATA, 20'h00002}, 32'hDEAD_BEEF, FUNC_WRITE, SIZE_WORD);
    send_access({SEL_PROGRAM, 20'hFFFFF}, 32'h0, FUNC_READ, SIZE_WORD);
    send_access({SEL_DATA, 20'h00000}, 32'h0, FUNC_READ, SIZE_WORD);
  endtask

  function automatic logic [19:0] pick_offset();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return 20'($urandom_range(255));
    if (pick < 80) return 20'hFFF00 | 20'($urandom_range(255));
    return 20'($urandom());
  endfunction

  // Mostly well-formed writes and reads of written bytes, plus noise
  task automatic send_random_access();
    logic [31:0] addr;
    logic [31:0] wdata;
    logic fn;
    logic [1:0] sz;
    logic [1:0] ridx;
    logic [19:0] off;
    int pick;
    int key;
    pick = $urandom_range(99);
    wdata = $urandom();
    fn = FUNC_WRITE;
    if (pick < 15) begin
      // Anything at all; never a plain read of unknown memory
      addr = $urandom();
      sz = 2'($urandom_range(3));
      fn = 1'($urandom_range(1));
      if (classify_access(addr, sz, ridx) == ST_OK) fn = FUNC_WRITE;
    end else if (pick < 30) begin
      // Broken access inside a valid region
      off = 20'($urandom());
      off[0] = 1'b1;
      sz = 2'($urandom_range(1, 3));
      fn = 1'($urandom_range(1));
      addr = {sel_of(2'($urandom_range(2))), off};
    end else if (pick < 65 || written_keys.size() == 0) begin
      sz = 2'($urandom_range(2));
      off = pick_offset() & ~((20'd1 << sz) - 20'd1);
      addr = {sel_of(2'($urandom_range(2))), off};
    end else begin
      // Read back from a written location; shrink to a byte if lanes are missing
      fn = FUNC_READ;
      key = written_keys[$urandom_range(written_keys.size() - 1)];
      ridx = key[21:20];
      sz = 2'($urandom_range(2));
      off = key[19:0] & ~((20'd1 << sz) - 20'd1);
      for (int i = 0; i < (1 << sz); i++) begin
        if (!mem_bytes.exists(byte_key(ridx, off + 20'(i)))) begin
          sz = SIZE_BYTE;
          off = key[19:0];
        end
      end
      addr = {sel_of(ridx), off};
    end
    send_access(addr, wdata, fn, sz);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (RANDOM_PER_PROFILE) send_random_access();
    wait_results_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 30;
    recv_idle_pct = 64;
    test_big_endian_lanes();
    test_error_priority();
    wait_results_drained();

    test_random_traffic(30, 64);
    test_random_traffic(64, 30);
    test_random_traffic(0, 0);

    $display("Ran %0d accesses, %0d results checked, across three idle profiles.",
             accesses_sent, results_checked);
    $display("Status mix: ok %0d, no region %0d, misaligned %0d, bad size %0d, range %0d.",
             status_count[int'(ST_OK)], status_count[int'(ST_NO_REGION)],
             status_count[int'(ST_MISALIGNED)], status_count[int'(ST_BAD_SIZE)],
             status_count[int'(ST_RANGE)]);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/sbe_pkg.sv
rtl/core/sbe_ram.sv
rtl/core/sbe_fifo.sv
rtl/core/sbe_front.sv
rtl/core/sbe_back.sv
rtl/core/segmented_big_endian_memory_access_unit.sv
tb/segmented_big_endian_memory_access_unit_test.sv
